@@ design/ptt_pkg.sv @@
// ptt_pkg: shared constants and codes for the priority task table
// no dependencies; imported by priority_task_table
`default_nettype none

package ptt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;

   localparam int ID_W    = 16;
   localparam int PRIO_W  = 8;
   localparam int ENTRY_W = ID_W + PRIO_W;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      FUNC_APPEND     = 2'd0,
      FUNC_REMOVE_ID  = 2'd1,
      FUNC_REMOVE_TOP = 2'd2,
      FUNC_LOOKUP     = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

endpackage

`default_nettype wire

@@ design/ptt_ram.sv @@
// ptt_ram: generic single write, single read RAM with registered read data
// standalone; used by priority_task_table for the entry store
`default_nettype none

module ptt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/priority_task_table.sv @@
// priority_task_table: insertion-ordered task table with append, remove by id,
// remove highest priority and lookup; depends on ptt_pkg and ptt_ram
//
//   channel  direction  ports                                        handshake
//   req      in         req_func req_task_id req_task_priority       req_valid/req_ready
//   rsp      out        rsp_status rsp_result_id rsp_result_priority rsp_valid/rsp_ready
//                       rsp_entry_count
//
// append and any request on an empty table are settled in the start state
// without a scan; lookup and both removals scan the held entries in order, and
// a removal then moves each entry above the removed slot down by one. the
// single ram read port sets the scan and the compaction at one entry per cycle.
// reset clears the count, the sequencer and the response valid flag; the entry
// ram is not cleared. a request is taken only while the sequencer is idle; a
// finished result waits in its register while the next request is accepted.
`default_nettype none

module priority_task_table
   import ptt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_func,
   input  wire logic [ID_W-1:0]     req_task_id,
   input  wire logic [PRIO_W-1:0]   req_task_priority,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [ID_W-1:0]          rsp_result_id,
   output logic [PRIO_W-1:0]        rsp_result_priority,
   output logic [COUNT_W-1:0]       rsp_entry_count
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_START  = 5'b00010,
      S_SCAN   = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   func_type          func_ff, func_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [CW-1:0]     pend_idx_ff, pend_idx_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;
   logic [CW-1:0]     best_pos_ff, best_pos_in;
   status_type        res_status_ff, res_status_in;
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic [PRIO_W-1:0] res_prio_ff, res_prio_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [PRIO_W-1:0]  rsp_prio_ff, rsp_prio_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [ID_W-1:0]    rd_id;
   logic [PRIO_W-1:0]  rd_prio;

   logic               issue_more;
   logic               last_entry;
   logic               take_new;
   logic [PRIO_W-1:0]  sel_prio;
   logic [ID_W-1:0]    sel_id;
   logic [CW-1:0]      sel_pos;
   logic [CW-1:0]      shift_wr_idx;
   logic [CW+COUNT_W-1:0] count_ext;

   ptt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_id   = rd_data[ENTRY_W-1:PRIO_W];
   assign rd_prio = rd_data[PRIO_W-1:0];

   assign issue_more   = (issue_ff < count_ff);
   assign last_entry   = ((pend_idx_ff + 1'b1) == count_ff);
   assign take_new     = (pend_idx_ff == '0) || (rd_prio > best_prio_ff);
   assign sel_prio     = take_new ? rd_prio : best_prio_ff;
   assign sel_id       = take_new ? rd_id : best_id_ff;
   assign sel_pos      = take_new ? pend_idx_ff : best_pos_ff;
   assign shift_wr_idx = pend_idx_ff - 1'b1;
   assign count_ext    = {{COUNT_W{1'b0}}, count_ff};
   assign rd_addr      = issue_ff[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      id_in         = id_ff;
      prio_in       = prio_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      best_prio_in  = best_prio_ff;
      best_id_in    = best_id_ff;
      best_pos_in   = best_pos_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_prio_in   = res_prio_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = {id_ff, prio_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in  = func_type'(req_func);
               id_in    = req_task_id;
               prio_in  = req_task_priority;
               issue_in = '0;
               state_in = S_START;
            end
         end
         S_START: begin
            if (func_ff == FUNC_APPEND) begin
               res_id_in   = id_ff;
               res_prio_in = prio_ff;
               if (count_ff < CW'(TABLE_DEPTH)) begin
                  wr_en         = 1'b1;
                  count_in      = count_ff + 1'b1;
                  res_status_in = ST_OK;
               end else begin
                  res_status_in = ST_FULL;
               end
               state_in = S_FINISH;
            end else if (count_ff == '0) begin
               res_status_in = ST_EMPTY;
               res_id_in     = '0;
               res_prio_in   = '0;
               state_in      = S_FINISH;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // reads run one ahead of the compare on the returned entry
            if (issue_more) begin
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff;
            end
            if (pend_ff) begin
               if (func_ff == FUNC_REMOVE_TOP) begin
                  best_prio_in = sel_prio;
                  best_id_in   = sel_id;
                  best_pos_in  = sel_pos;
                  if (last_entry) begin
                     res_status_in = ST_OK;
                     res_id_in     = sel_id;
                     res_prio_in   = sel_prio;
                     issue_in      = sel_pos + 1'b1;
                     pend_in       = 1'b0;
                     state_in      = S_SHIFT;
                  end
               end else if (rd_id == id_ff) begin
                  res_status_in = ST_OK;
                  res_id_in     = id_ff;
                  res_prio_in   = rd_prio;
                  pend_in       = 1'b0;
                  if (func_ff == FUNC_LOOKUP) begin
                     state_in = S_FINISH;
                  end else begin
                     issue_in = pend_idx_ff + 1'b1;
                     state_in = S_SHIFT;
                  end
               end else if (last_entry) begin
                  res_status_in = ST_NOT_FOUND;
                  res_id_in     = id_ff;
                  res_prio_in   = '0;
                  pend_in       = 1'b0;
                  state_in      = S_FINISH;
               end
            end
         end
         S_SHIFT: begin
            // move entry i+1 down to i, one per cycle
            if (issue_more) begin
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = shift_wr_idx[AW-1:0];
               wr_data = rd_data;
            end
            if (!issue_more && !pend_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_prio_in   = res_prio_ff;
               rsp_count_in  = count_ext[COUNT_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      id_ff         <= id_in;
      prio_ff       <= prio_in;
      issue_ff      <= issue_in;
      pend_idx_ff   <= pend_idx_in;
      best_prio_ff  <= best_prio_in;
      best_id_ff    <= best_id_in;
      best_pos_ff   <= best_pos_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_prio_ff   <= res_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_id       = rsp_id_ff;
   assign rsp_result_priority = rsp_prio_ff;
   assign rsp_entry_count     = rsp_count_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |->
         ($past(state_ff) == S_START || $past(state_ff) == S_SHIFT))
      else $error("entry count changed outside append or compaction");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == S_FINISH))
      else $error("response raised without a finished request");

   a_shift_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && pend_ff) |-> (pend_idx_ff != '0 && pend_idx_ff < count_ff))
      else $error("compaction write outside held entries");
`endif

endmodule

`default_nettype wire
